// ----- hdl/rtc_pkg.sv -----
package rtc_pkg;

    localparam int unsigned SEC_W   = 6;
    localparam int unsigned MIN_W   = 6;
    localparam int unsigned HOUR_W  = 5;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned YEAR_W  = 14;

    localparam logic [SEC_W-1:0]   SECONDS_PER_MINUTE = SEC_W'(60);
    localparam logic [MIN_W-1:0]   MINUTES_PER_HOUR   = MIN_W'(60);
    localparam logic [HOUR_W-1:0]  HOURS_PER_DAY      = HOUR_W'(24);
    localparam logic [MONTH_W-1:0] MONTHS_PER_YEAR    = MONTH_W'(12);
    localparam logic [MONTH_W-1:0] MONTH_JANUARY      = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_FEBRUARY     = MONTH_W'(2);
    localparam logic [DAY_W-1:0]   DAY_FIRST          = DAY_W'(1);
    localparam logic [DAY_W-1:0]   DAYS_LONG_MONTH    = DAY_W'(31);
    localparam logic [DAY_W-1:0]   DAYS_LEAP_FEBRUARY = DAY_W'(29);
    localparam logic [YEAR_W-1:0]  YEAR_LIMIT         = YEAR_W'(9999);
    localparam logic [YEAR_W-1:0]  YEAR_RESET         = YEAR_W'(2000);

    localparam logic [DAY_W-1:0] MONTH_DAYS [12] = '{
        DAY_W'(31), DAY_W'(28), DAY_W'(31), DAY_W'(30), DAY_W'(31), DAY_W'(30),
        DAY_W'(31), DAY_W'(31), DAY_W'(30), DAY_W'(31), DAY_W'(30), DAY_W'(31)
    };

    // Reciprocal of 25 for 14-bit years: floor(y * 20972 / 2^19) == y / 25.
    localparam int unsigned   DIV25_SHIFT = 19;
    localparam int unsigned   DIV25_MUL_W = 15;
    localparam int unsigned   DIV25_PROD_W = YEAR_W + DIV25_MUL_W;
    localparam int unsigned   DIV25_QUO_W = DIV25_PROD_W - DIV25_SHIFT;
    localparam logic [DIV25_MUL_W-1:0] DIV25_MUL = DIV25_MUL_W'(20972);
    localparam logic [YEAR_W-1:0]      DIVISOR_25 = YEAR_W'(25);

    typedef struct packed {
        logic [SEC_W-1:0]   second;
        logic [MIN_W-1:0]   minute;
        logic [HOUR_W-1:0]  hour;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } rtc_time_t;

    localparam rtc_time_t RTC_RESET = '{
        second: '0, minute: '0, hour: '0,
        day: DAY_FIRST, month: MONTH_JANUARY, year: YEAR_RESET
    };

    // Divisible by 100 is divisible by 4 and by 25; by 400 is by 16 and by 25.
    function automatic logic leap_year(input logic [YEAR_W-1:0] y);
        logic [DIV25_PROD_W-1:0] prod;
        logic [DIV25_QUO_W-1:0]  quo;
        logic [YEAR_W-1:0]       rem;
        logic                    mul25;
        logic                    div4;
        logic                    div16;
        prod  = DIV25_PROD_W'(y) * DIV25_PROD_W'(DIV25_MUL);
        quo   = prod[DIV25_PROD_W-1:DIV25_SHIFT];
        rem   = y - YEAR_W'(YEAR_W'(quo) * DIVISOR_25);
        mul25 = (rem == '0);
        div4  = (y[1:0] == 2'b00);
        div16 = (y[3:0] == 4'b0000);
        return (div4 && !mul25) || (div16 && mul25);
    endfunction

    function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] m,
                                                      input logic [YEAR_W-1:0]  y);
        logic [MONTH_W-1:0] idx;
        idx = m - MONTH_JANUARY;
        if (m < MONTH_JANUARY || m > MONTHS_PER_YEAR) begin
            return DAYS_LONG_MONTH;
        end else if (m == MONTH_FEBRUARY && leap_year(y)) begin
            return DAYS_LEAP_FEBRUARY;
        end
        return MONTH_DAYS[idx];
    endfunction

endpackage

// ----- hdl/rtc_advance.sv -----
module rtc_advance
    import rtc_pkg::*;
(
    input  logic      action,
    input  rtc_time_t load_time,
    input  rtc_time_t cur_time,
    output rtc_time_t next_time,
    output logic      day_rolled
);

    logic            sec_wrap;
    logic            min_wrap;
    logic            hour_wrap;
    logic [DAY_W-1:0] month_len;
    rtc_time_t       tick_time;

    // Counters may hold loaded values out of range, so compare with >=.
    assign sec_wrap  = (cur_time.second >= SECONDS_PER_MINUTE - SEC_W'(1));
    assign min_wrap  = (cur_time.minute >= MINUTES_PER_HOUR - MIN_W'(1));
    assign hour_wrap = (cur_time.hour >= HOURS_PER_DAY - HOUR_W'(1));
    assign month_len = days_in_month(cur_time.month, cur_time.year);

    always_comb begin
        tick_time = cur_time;
        if (!sec_wrap) begin
            tick_time.second = cur_time.second + SEC_W'(1);
        end else begin
            tick_time.second = '0;
            if (!min_wrap) begin
                tick_time.minute = cur_time.minute + MIN_W'(1);
            end else begin
                tick_time.minute = '0;
                if (!hour_wrap) begin
                    tick_time.hour = cur_time.hour + HOUR_W'(1);
                end else begin
                    tick_time.hour = '0;
                    if (cur_time.day < month_len) begin
                        tick_time.day = cur_time.day + DAY_W'(1);
                    end else begin
                        tick_time.day = DAY_FIRST;
                        if (cur_time.month < MONTHS_PER_YEAR) begin
                            tick_time.month = cur_time.month + MONTH_W'(1);
                        end else begin
                            tick_time.month = MONTH_JANUARY;
                            if (cur_time.year >= YEAR_LIMIT) begin
                                tick_time.year = '0;
                            end else begin
                                tick_time.year = cur_time.year + YEAR_W'(1);
                            end
                        end
                    end
                end
            end
        end
    end

    assign next_time  = action ? load_time : tick_time;
    assign day_rolled = !action && sec_wrap && min_wrap && hour_wrap;

endmodule

// ----- hdl/calendar_clock_second_tick.sv -----
// Real-time clock and calendar advanced by one-second ticks.
// Input channel (s_valid/s_ready): s_action = 0 is a one-second tick,
// s_action = 1 loads the s_load_* time and date fields as given.
// Result channel (m_valid/m_ready): the full time and date after each item,
// plus m_day_rolled, set when a tick carried from 23:59:59 into a new day.
// Every item produces exactly one result, in the cycle after it is accepted.
// Throughput is one item per cycle: the calendar registers are updated at
// acceptance and double as the result register, and the carry chain with
// the month-length and leap-year decode is a single combinational stage.
// While a result waits, s_ready stays high only in a cycle where the
// receiver takes it (m_ready high); a stalled receiver therefore holds off
// the next item and the result stays stable.
// Synchronous active-low reset sets 00:00:00 on January 1, 2000 and
// empties the result register.
module calendar_clock_second_tick
    import rtc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_action,
    input  logic [SEC_W-1:0]   s_load_second,
    input  logic [MIN_W-1:0]   s_load_minute,
    input  logic [HOUR_W-1:0]  s_load_hour,
    input  logic [DAY_W-1:0]   s_load_day,
    input  logic [MONTH_W-1:0] s_load_month,
    input  logic [YEAR_W-1:0]  s_load_year,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [SEC_W-1:0]   m_cur_second,
    output logic [MIN_W-1:0]   m_cur_minute,
    output logic [HOUR_W-1:0]  m_cur_hour,
    output logic [DAY_W-1:0]   m_cur_day,
    output logic [MONTH_W-1:0] m_cur_month,
    output logic [YEAR_W-1:0]  m_cur_year,
    output logic               m_day_rolled
);

    rtc_time_t time_reg;
    rtc_time_t time_next;
    rtc_time_t load_time;
    logic      rolled_reg;
    logic      rolled_next;
    logic      valid_reg;
    logic      accept;

    assign load_time = '{
        second: s_load_second, minute: s_load_minute, hour: s_load_hour,
        day: s_load_day, month: s_load_month, year: s_load_year
    };

    assign s_ready = !valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    rtc_advance u_advance (
        .action     (s_action),
        .load_time  (load_time),
        .cur_time   (time_reg),
        .next_time  (time_next),
        .day_rolled (rolled_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_reg   <= RTC_RESET;
            rolled_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                time_reg   <= time_next;
                rolled_reg <= rolled_next;
                valid_reg  <= 1'b1;
            end else if (m_ready) begin
                valid_reg  <= 1'b0;
            end
        end
    end

    assign m_valid      = valid_reg;
    assign m_cur_second = time_reg.second;
    assign m_cur_minute = time_reg.minute;
    assign m_cur_hour   = time_reg.hour;
    assign m_cur_day    = time_reg.day;
    assign m_cur_month  = time_reg.month;
    assign m_cur_year   = time_reg.year;
    assign m_day_rolled = rolled_reg;

endmodule

// ----- hdl/rtc_checker.sv -----
module rtc_checker
    import rtc_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               s_action,
    input logic [SEC_W-1:0]   s_load_second,
    input logic [MIN_W-1:0]   s_load_minute,
    input logic [HOUR_W-1:0]  s_load_hour,
    input logic [DAY_W-1:0]   s_load_day,
    input logic [MONTH_W-1:0] s_load_month,
    input logic [YEAR_W-1:0]  s_load_year,
    input logic               m_valid,
    input logic               m_ready,
    input logic [SEC_W-1:0]   m_cur_second,
    input logic [MIN_W-1:0]   m_cur_minute,
    input logic [HOUR_W-1:0]  m_cur_hour,
    input logic [DAY_W-1:0]   m_cur_day,
    input logic [MONTH_W-1:0] m_cur_month,
    input logic [YEAR_W-1:0]  m_cur_year,
    input logic               m_day_rolled
);

    // A stalled result holds its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cur_second) && $stable(m_cur_minute)
            && $stable(m_cur_hour) && $stable(m_cur_day) && $stable(m_cur_month)
            && $stable(m_cur_year) && $stable(m_day_rolled))
        else $error("stalled result changed");

    // An empty result register never blocks the input.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked while result register empty");

    // A load shows up unchanged as the next result, with no day carry.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_action |=> m_valid && !m_day_rolled
            && m_cur_second == $past(s_load_second) && m_cur_minute == $past(s_load_minute)
            && m_cur_hour == $past(s_load_hour) && m_cur_day == $past(s_load_day)
            && m_cur_month == $past(s_load_month) && m_cur_year == $past(s_load_year))
        else $error("loaded time not reported");

    // A day carry leaves the clock at midnight on the first day or a later one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_day_rolled |-> m_cur_second == '0 && m_cur_minute == '0
            && m_cur_hour == '0 && m_cur_day != '0)
        else $error("day carry without midnight");

endmodule

bind calendar_clock_second_tick rtc_checker u_rtc_checker (.*);

// ----- tb/calendar_clock_second_tick_tb.sv -----
module calendar_clock_second_tick_tb;
    import rtc_pkg::*;

    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_LOAD = 1'b1;

    localparam int unsigned RANDOM_ITEMS     = 1300;
    localparam int unsigned LONG_HOLD_CYCLES = 120;
    localparam int unsigned MAX_REPORTS      = 10;
    localparam int unsigned DRAIN_LIMIT      = 200;

    typedef struct packed {
        rtc_time_t now;
        logic      day_rolled;
    } clock_reading_t;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_action;
    logic [SEC_W-1:0]   s_load_second;
    logic [MIN_W-1:0]   s_load_minute;
    logic [HOUR_W-1:0]  s_load_hour;
    logic [DAY_W-1:0]   s_load_day;
    logic [MONTH_W-1:0] s_load_month;
    logic [YEAR_W-1:0]  s_load_year;
    logic               m_valid;
    logic               m_ready;
    logic [SEC_W-1:0]   m_cur_second;
    logic [MIN_W-1:0]   m_cur_minute;
    logic [HOUR_W-1:0]  m_cur_hour;
    logic [DAY_W-1:0]   m_cur_day;
    logic [MONTH_W-1:0] m_cur_month;
    logic [YEAR_W-1:0]  m_cur_year;
    logic               m_day_rolled;

    rtc_time_t      clock_state;
    clock_reading_t expected_readings[$];

    int unsigned mismatch_count  = 0;
    int unsigned results_checked = 0;
    int unsigned ticks_sent      = 0;
    int unsigned loads_sent      = 0;
    int unsigned day_carries     = 0;

    bit tx_no_idle        = 1'b0;
    bit rx_no_idle        = 1'b0;
    bit long_hold_request = 1'b0;

    calendar_clock_second_tick dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_load_second (s_load_second),
        .s_load_minute (s_load_minute),
        .s_load_hour   (s_load_hour),
        .s_load_day    (s_load_day),
        .s_load_month  (s_load_month),
        .s_load_year   (s_load_year),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_cur_second  (m_cur_second),
        .m_cur_minute  (m_cur_minute),
        .m_cur_hour    (m_cur_hour),
        .m_cur_day     (m_cur_day),
        .m_cur_month   (m_cur_month),
        .m_cur_year    (m_cur_year),
        .m_day_rolled  (m_day_rolled)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic bit is_leap_year(int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned month_length(int unsigned m, int unsigned y);
        int unsigned lengths[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        if (m < 1 || m > 12) begin
            return 31;
        end
        if (m == 2 && is_leap_year(y)) begin
            return 29;
        end
        return lengths[m - 1];
    endfunction

    function automatic void advance_date();
        if (clock_state.day >= month_length(clock_state.month, clock_state.year)) begin
            clock_state.day = DAY_FIRST;
            if (clock_state.month >= MONTHS_PER_YEAR) begin
                clock_state.month = MONTH_JANUARY;
                clock_state.year = (clock_state.year >= YEAR_LIMIT) ? '0
                                                                    : clock_state.year + 1'b1;
            end else begin
                clock_state.month = clock_state.month + 1'b1;
            end
        end else begin
            clock_state.day = clock_state.day + 1'b1;
        end
    endfunction

    // Every carry compares with greater-or-equal, so a loaded value past its
    // range rolls over at the next tick that carries into that field.
    function automatic clock_reading_t predict_reading(logic action, rtc_time_t load);
        clock_reading_t r;
        r.day_rolled = 1'b0;
        if (action == ACT_LOAD) begin
            clock_state = load;
        end else if (int'(clock_state.second) + 1 < int'(SECONDS_PER_MINUTE)) begin
            clock_state.second = clock_state.second + 1'b1;
        end else begin
            clock_state.second = '0;
            if (int'(clock_state.minute) + 1 < int'(MINUTES_PER_HOUR)) begin
                clock_state.minute = clock_state.minute + 1'b1;
            end else begin
                clock_state.minute = '0;
                if (int'(clock_state.hour) + 1 < int'(HOURS_PER_DAY)) begin
                    clock_state.hour = clock_state.hour + 1'b1;
                end else begin
                    clock_state.hour = '0;
                    r.day_rolled = 1'b1;
                    advance_date();
                end
            end
        end
        r.now = clock_state;
        return r;
    endfunction

    function automatic string format_reading(clock_reading_t r);
        return $sformatf("%0d:%0d:%0d day %0d month %0d year %0d rolled %0b",
                         r.now.hour, r.now.minute, r.now.second, r.now.day,
                         r.now.month, r.now.year, r.day_rolled);
    endfunction

    function automatic void note_failure(string what, clock_reading_t want,
                                         clock_reading_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: %s: expected %s, got %s", $time, what,
                     format_reading(want), format_reading(got));
        end
    endfunction

    always @(posedge aclk) begin : result_check
        clock_reading_t want;
        clock_reading_t got;
        rtc_time_t      load;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got.now.second = m_cur_second;
                got.now.minute = m_cur_minute;
                got.now.hour   = m_cur_hour;
                got.now.day    = m_cur_day;
                got.now.month  = m_cur_month;
                got.now.year   = m_cur_year;
                got.day_rolled = m_day_rolled;
                if (expected_readings.size() == 0) begin
                    note_failure("result with no item outstanding", '0, got);
                end else begin
                    want = expected_readings.pop_front();
                    results_checked++;
                    if (got.now.second !== want.now.second ||
                        got.now.minute !== want.now.minute ||
                        got.now.hour   !== want.now.hour   ||
                        got.now.day    !== want.now.day    ||
                        got.now.month  !== want.now.month  ||
                        got.now.year   !== want.now.year   ||
                        got.day_rolled !== want.day_rolled) begin
                        note_failure("mismatch", want, got);
                    end
                end
            end
            // The result of an accepted item shows up no earlier than the
            // next edge, so predicting after the check keeps the order.
            if (s_valid && s_ready) begin
                load = {s_load_second, s_load_minute, s_load_hour,
                        s_load_day, s_load_month, s_load_year};
                want = predict_reading(s_action, load);
                expected_readings.push_back(want);
                if (s_action == ACT_LOAD) begin
                    loads_sent++;
                end else begin
                    ticks_sent++;
                end
                if (want.day_rolled) begin
                    day_carries++;
                end
            end
        end
    end

    initial begin : result_sink
        int unsigned stall;
        m_ready = 1'b0;
        @(negedge aclk);
        forever begin
            if (long_hold_request) begin
                long_hold_request = 1'b0;
                stall = LONG_HOLD_CYCLES;
            end else begin
                stall = rx_no_idle ? 0 : $urandom_range(0, 9);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high, so back-to-back items keep it asserted.
    task automatic send_item(logic action, rtc_time_t fields);
        int unsigned gap;
        gap = tx_no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_action      <= action;
        s_load_second <= fields.second;
        s_load_minute <= fields.minute;
        s_load_hour   <= fields.hour;
        s_load_day    <= fields.day;
        s_load_month  <= fields.month;
        s_load_year   <= fields.year;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    function automatic rtc_time_t random_fields();
        logic [63:0] bits;
        bits = {$urandom(), $urandom()};
        return bits[$bits(rtc_time_t)-1:0];
    endfunction

    task automatic send_tick();
        send_item(ACT_TICK, random_fields());
    endtask

    task automatic send_load(int unsigned sec, int unsigned min, int unsigned hr,
                             int unsigned dd, int unsigned mm, int unsigned yy);
        rtc_time_t f;
        f.second = SEC_W'(sec);
        f.minute = MIN_W'(min);
        f.hour   = HOUR_W'(hr);
        f.day    = DAY_W'(dd);
        f.month  = MONTH_W'(mm);
        f.year   = YEAR_W'(yy);
        send_item(ACT_LOAD, f);
    endtask

    // Mostly the last seconds before a day, month or year boundary, so that
    // a short run of ticks goes through the full carry chain.
    function automatic rtc_time_t near_rollover_time();
        rtc_time_t f;
        f.second = SEC_W'(60 - $urandom_range(1, 6));
        f.minute = ($urandom_range(0, 3) == 0) ? MIN_W'($urandom_range(0, 59)) : MIN_W'(59);
        f.hour   = ($urandom_range(0, 3) == 0) ? HOUR_W'($urandom_range(0, 23)) : HOUR_W'(23);
        f.month  = MONTH_W'($urandom_range(1, 12));
        case ($urandom_range(0, 3))
            0: begin
                f.year = YEAR_W'($urandom_range(0, 9999));
            end
            1: begin
                f.year = YEAR_W'(9999 - $urandom_range(0, 1));
            end
            2: begin
                f.year = YEAR_W'(100 * $urandom_range(0, 99));
            end
            default: begin
                f.year = YEAR_W'(4 * $urandom_range(0, 2499));
            end
        endcase
        if ($urandom_range(0, 3) == 0) begin
            f.day = DAY_W'($urandom_range(1, 31));
        end else begin
            f.day = DAY_W'(month_length(f.month, f.year) - $urandom_range(0, 1));
        end
        return f;
    endfunction

    task automatic test_reset_state();
        send_tick();
    endtask

    task automatic test_calendar_edges();
        send_load(59, 59, 23, 31, 12, 9998);
        send_tick();
        send_load(59, 59, 23, 31, 12, 9999);
        send_tick();
        send_load(59, 59, 23, 28, 2, 2024);
        send_tick();
        send_load(59, 59, 23, 28, 2, 1900);
        send_tick();
        send_load(59, 59, 23, 29, 2, 2000);
        send_tick();
    endtask

    task automatic test_out_of_range_loads();
        // All fields at their widest values: everything rolls on one tick.
        send_load(63, 63, 31, 31, 15, 16383);
        send_tick();
        // Day zero and month zero.
        send_load(59, 59, 23, 0, 0, 0);
        send_tick();
        send_load(59, 59, 23, 31, 13, 500);
        send_tick();
        send_load(60, 0, 0, 1, 1, 0);
        send_tick();
    endtask

    task automatic test_stalled_receiver();
        tx_no_idle        = 1'b1;
        long_hold_request = 1'b1;
        repeat (30) send_tick();
        tx_no_idle = 1'b0;
    endtask

    task automatic test_random_calendar();
        int unsigned sent;
        int unsigned ticks;
        int unsigned mode;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 7) == 0) begin
                tx_no_idle = ~tx_no_idle;
            end
            if ($urandom_range(0, 7) == 0) begin
                rx_no_idle = ~rx_no_idle;
            end
            mode = $urandom_range(0, 9);
            if (mode < 7) begin
                send_item(ACT_LOAD, near_rollover_time());
                ticks = $urandom_range(1, 12);
                sent++;
            end else if (mode < 9) begin
                send_item(ACT_LOAD, random_fields());
                ticks = $urandom_range(0, 4);
                sent++;
            end else begin
                ticks = $urandom_range(1, 20);
            end
            repeat (ticks) send_tick();
            sent += ticks;
        end
        tx_no_idle = 1'b0;
        rx_no_idle = 1'b0;
    endtask

    initial begin : main_sequence
        int unsigned waited;
        clock_reading_t leftover;
        clock_state   = RTC_RESET;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_action      = ACT_TICK;
        s_load_second = '0;
        s_load_minute = '0;
        s_load_hour   = '0;
        s_load_day    = '0;
        s_load_month  = '0;
        s_load_year   = '0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_state();
        test_calendar_edges();
        test_out_of_range_loads();
        test_stalled_receiver();
        test_random_calendar();

        s_valid <= 1'b0;
        waited = 0;
        while (expected_readings.size() > 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (4) @(posedge aclk);
        while (expected_readings.size() > 0) begin
            leftover = expected_readings.pop_front();
            note_failure("no result for item", leftover, '0);
        end

        $display("Sent %0d ticks and %0d loads with %0d day carries; %0d results checked.",
                 ticks_sent, loads_sent, day_carries, results_checked);
        $display("Included leap and century years, year wrap, out-of-range loads and a %0d-cycle receiver stall.",
                 LONG_HOLD_CYCLES);
        if (mismatch_count == 0) begin
            $display("calendar_clock_second_tick_tb passed");
        end else begin
            $display("calendar_clock_second_tick_tb failed");
        end
        $finish;
    end

    initial begin : watchdog
        #4000000;
        $display("Timed out with %0d results outstanding.", expected_readings.size());
        $display("calendar_clock_second_tick_tb failed");
        $finish;
    end

endmodule
